/* sv/dpr_pkg.sv */
package dpr_pkg;

    localparam int BUF_DEPTH  = 512;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W      = ADDR_W;
    localparam int IDX_W      = 9;
    localparam int LEN_W      = 9;
    localparam int SUM_W      = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // input kinds
    localparam logic [1:0] IN_KIND_BYTE  = 2'd0;
    localparam logic [1:0] IN_KIND_END   = 2'd1;
    localparam logic [1:0] IN_KIND_READ  = 2'd2;

    // result kinds
    localparam logic [1:0] OUT_KIND_BYTE    = 2'd0;
    localparam logic [1:0] OUT_KIND_VERDICT = 2'd1;
    localparam logic [1:0] OUT_KIND_DATA    = 2'd2;

    // command codes between front and back
    localparam logic [1:0] CMD_NAK   = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_ABORT = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [CNT_W-1:0] len;
        logic             has_seq;
        logic [7:0]       seq0;
        logic [7:0]       seq1;
        logic [7:0]       data;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic             good;
        logic [LEN_W-1:0] len;
        logic             seq;
        logic             aborted;
        logic             last;
    } res_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h41 && c <= 8'h46)
            v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 4'(c - 8'h57);
        else if (c >= 8'h30 && c <= 8'h39)
            v = 4'(c - 8'h30);
        return v;
    endfunction

endpackage

/* sv/dpr_front.sv */
module dpr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        in_kind,
    input  logic [7:0]                        in_byte,
    input  logic [dpr_pkg::IDX_W-1:0]         in_index,
    input  logic [dpr_pkg::FIFO_CNT_W-1:0]    fifo_count,
    output logic                              push,
    output dpr_pkg::cmd_t                     push_cmd
);
    import dpr_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_HEX1 = 2'd2;
    localparam logic [1:0] PH_HEX2 = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [7:0]       sum_reg, sum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       hi_reg, hi_next;
    logic [CNT_W-1:0] slen_reg, slen_next;
    logic             sseq_reg, sseq_next;
    logic [7:0]       seq0_reg, seq0_next;
    logic [7:0]       seq1_reg, seq1_next;
    logic [7:0]       seq2_reg, seq2_next;

    logic             s2_valid_reg, s2_valid_next;
    cmd_t             s2_cmd_reg, s2_cmd_next;
    logic             s2_range_reg, s2_range_next;
    logic [7:0]       rdata_reg;

    logic [7:0]       store_mem [BUF_DEPTH];

    logic             accept;
    logic             wr_en;
    logic             rd_en;
    logic [SUM_W-1:0] rd_sum;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]       sent_sum;
    logic [FIFO_CNT_W:0] occupancy;

    // count the entry still in the second stage against the queue room
    assign occupancy = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(s2_valid_reg);
    assign in_ready  = (occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    assign accept    = in_valid && in_ready;

    assign rd_sum   = SUM_W'(in_index) + (sseq_reg ? SUM_W'(3) : SUM_W'(0));
    assign rd_addr  = rd_sum[ADDR_W-1:0];
    assign rd_en    = accept && (in_kind == IN_KIND_READ);
    assign sent_sum = {hi_reg, hex_value(in_byte)};

    always_comb
    begin
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        hi_next       = hi_reg;
        slen_next     = slen_reg;
        sseq_next     = sseq_reg;
        seq0_next     = seq0_reg;
        seq1_next     = seq1_reg;
        seq2_next     = seq2_reg;
        wr_en         = 1'b0;
        s2_valid_next = 1'b0;
        s2_cmd_next   = s2_cmd_reg;
        s2_range_next = s2_range_reg;

        if (accept)
        begin
            unique case (in_kind)
                IN_KIND_BYTE:
                begin
                    unique case (phase_reg)
                        PH_HUNT:
                        begin
                            if (in_byte == CH_DOLLAR)
                            begin
                                phase_next = PH_DATA;
                                sum_next   = 8'd0;
                                count_next = '0;
                            end
                        end
                        PH_DATA:
                        begin
                            if (in_byte == CH_HASH)
                                phase_next = PH_HEX1;
                            else if (count_reg < CNT_W'(BUF_DEPTH - 1))
                            begin
                                wr_en      = 1'b1;
                                sum_next   = sum_reg + in_byte;
                                count_next = count_reg + CNT_W'(1);
                                if (count_reg == CNT_W'(0))
                                    seq0_next = in_byte;
                                if (count_reg == CNT_W'(1))
                                    seq1_next = in_byte;
                                if (count_reg == CNT_W'(2))
                                    seq2_next = in_byte;
                                // drop the packet once the store holds BUF_DEPTH - 1 bytes
                                if (count_reg >= CNT_W'(BUF_DEPTH - 2))
                                    phase_next = PH_HUNT;
                            end
                            else
                                phase_next = PH_HUNT;
                        end
                        PH_HEX1:
                        begin
                            hi_next    = hex_value(in_byte);
                            phase_next = PH_HEX2;
                        end
                        PH_HEX2:
                        begin
                            phase_next          = PH_HUNT;
                            s2_valid_next       = 1'b1;
                            s2_cmd_next.seq0    = seq0_reg;
                            s2_cmd_next.seq1    = seq1_reg;
                            s2_cmd_next.data    = 8'd0;
                            s2_range_next       = 1'b0;
                            if (sent_sum != sum_reg)
                            begin
                                slen_next           = count_reg;
                                sseq_next           = 1'b0;
                                s2_cmd_next.cmd     = CMD_NAK;
                                s2_cmd_next.len     = count_reg;
                                s2_cmd_next.has_seq = 1'b0;
                            end
                            else if (count_reg >= CNT_W'(3) && seq2_reg == CH_COLON)
                            begin
                                slen_next           = count_reg - CNT_W'(3);
                                sseq_next           = 1'b1;
                                s2_cmd_next.cmd     = CMD_ACK;
                                s2_cmd_next.len     = count_reg - CNT_W'(3);
                                s2_cmd_next.has_seq = 1'b1;
                            end
                            else
                            begin
                                slen_next           = count_reg;
                                sseq_next           = 1'b0;
                                s2_cmd_next.cmd     = CMD_ACK;
                                s2_cmd_next.len     = count_reg;
                                s2_cmd_next.has_seq = 1'b0;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
                IN_KIND_END:
                begin
                    phase_next          = PH_HUNT;
                    s2_valid_next       = 1'b1;
                    s2_cmd_next.cmd     = CMD_ABORT;
                    s2_cmd_next.len     = '0;
                    s2_cmd_next.has_seq = 1'b0;
                    s2_range_next       = 1'b0;
                end
                IN_KIND_READ:
                begin
                    s2_valid_next       = 1'b1;
                    s2_cmd_next.cmd     = CMD_READ;
                    s2_cmd_next.len     = '0;
                    s2_cmd_next.has_seq = 1'b0;
                    s2_range_next       = (SUM_W'(in_index) < SUM_W'(slen_reg))
                                          && (rd_sum < SUM_W'(BUF_DEPTH));
                end
                default:
                begin
                    s2_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            sum_reg      <= 8'd0;
            count_reg    <= '0;
            hi_reg       <= 4'd0;
            slen_reg     <= '0;
            sseq_reg     <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            hi_reg       <= hi_next;
            slen_reg     <= slen_next;
            sseq_reg     <= sseq_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq0_reg     <= seq0_next;
        seq1_reg     <= seq1_next;
        seq2_reg     <= seq2_next;
        s2_cmd_reg   <= s2_cmd_next;
        s2_range_reg <= s2_range_next;
    end

    // read ahead of any later write, so a read sees the store as of its transfer
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[count_reg] <= in_byte;
        if (rd_en)
            rdata_reg <= store_mem[rd_addr];
    end

    always_comb
    begin
        push_cmd = s2_cmd_reg;
        if (s2_cmd_reg.cmd == CMD_READ)
            push_cmd.data = s2_range_reg ? rdata_reg : 8'd0;
    end

    assign push = s2_valid_reg;

endmodule

/* sv/dpr_fifo.sv */
module dpr_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  dpr_pkg::cmd_t                   push_cmd,
    input  logic                            pop,
    output logic                            head_valid,
    output dpr_pkg::cmd_t                   head_cmd,
    output logic [dpr_pkg::FIFO_CNT_W-1:0]  count
);
    import dpr_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* sv/dpr_back.sv */
module dpr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  dpr_pkg::cmd_t  head_cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output dpr_pkg::res_t  out_res
);
    import dpr_pkg::*;

    logic [1:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    res_t       res_reg, res_next;
    res_t       cur;
    logic       load;

    always_comb
    begin
        cur         = '0;
        cur.kind    = OUT_KIND_VERDICT;
        unique case (head_cmd.cmd)
            CMD_NAK:
            begin
                if (step_reg == 2'd0)
                begin
                    cur.kind = OUT_KIND_BYTE;
                    cur.data = CH_MINUS;
                end
                else
                begin
                    cur.len  = LEN_W'(head_cmd.len);
                    cur.last = 1'b1;
                end
            end
            CMD_ACK:
            begin
                if (step_reg == 2'd0)
                begin
                    cur.kind = OUT_KIND_BYTE;
                    cur.data = CH_PLUS;
                end
                else if (head_cmd.has_seq && step_reg == 2'd1)
                begin
                    cur.kind = OUT_KIND_BYTE;
                    cur.data = head_cmd.seq0;
                end
                else if (head_cmd.has_seq && step_reg == 2'd2)
                begin
                    cur.kind = OUT_KIND_BYTE;
                    cur.data = head_cmd.seq1;
                end
                else
                begin
                    cur.good = 1'b1;
                    cur.len  = LEN_W'(head_cmd.len);
                    cur.seq  = head_cmd.has_seq;
                    cur.last = 1'b1;
                end
            end
            CMD_ABORT:
            begin
                cur.aborted = 1'b1;
                cur.last    = 1'b1;
            end
            CMD_READ:
            begin
                cur.kind = OUT_KIND_DATA;
                cur.data = head_cmd.data;
                cur.last = 1'b1;
            end
            default:
            begin
                cur.last = 1'b1;
            end
        endcase
    end

    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && cur.last;

    always_comb
    begin
        step_next      = step_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            res_next       = cur;
            out_valid_next = 1'b1;
            step_next      = cur.last ? 2'd0 : step_reg + 2'd1;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

/* sv/debug_packet_receiver_top.sv */
// The first result of an item passes through the second stage register, the
// command queue and the result register. The input takes one item per cycle
// while the command queue has room; results leave at one per cycle while the
// sink is ready, so a checksum item can yield a burst of four results.
// A four-entry command queue between the classifier and the result sequencer
// absorbs that burst. Reset clears all control state; the payload store is not cleared and needs no clearing pass.
module debug_packet_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // rx_byte[7:0], read_index[16:8], zero[23:17]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_byte[7:0], packet_good[8],
                                        // packet_length[17:9], seq_present[18],
                                        // aborted[19], zero[23:20]
    output logic [1:0]  m_axis_tuser,   // out_kind[1:0]
    output logic        m_axis_tlast
);
    import dpr_pkg::*;

    logic                  push;
    cmd_t                  push_cmd;
    logic                  pop;
    logic                  head_valid;
    cmd_t                  head_cmd;
    logic [FIFO_CNT_W-1:0] fifo_count;
    res_t                  res;

    dpr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser),
        .in_byte    (s_axis_tdata[7:0]),
        .in_index   (s_axis_tdata[16:8]),
        .fifo_count (fifo_count),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    dpr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .count      (fifo_count)
    );

    dpr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    assign m_axis_tdata = {4'd0, res.aborted, res.seq, res.len, res.good, res.data};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && (fifo_count == FIFO_CNT_W'(FIFO_DEPTH)) && !pop))
        else $error("command queue overflow");

    a_verdict_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == OUT_KIND_VERDICT) |->
            (m_axis_tdata[7:0] == 8'd0 && m_axis_tlast))
        else $error("verdict carries a byte or is not last");

    a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[19]) |->
            (m_axis_tdata[18:8] == 11'd0))
        else $error("abort verdict with packet fields set");

    a_byte_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == OUT_KIND_BYTE || m_axis_tuser == OUT_KIND_DATA))
            |-> (m_axis_tdata[23:8] == 16'd0))
        else $error("byte result with verdict fields set");

endmodule

/* sim/debug_packet_receiver_top_test.sv */
`timescale 1ns / 100ps

module debug_packet_receiver_top_test;

    import dpr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 380;
    localparam int QUIET_TAIL     = 16;

    class reply_scoreboard;

        typedef enum logic [1:0] {
            ST_HUNT,
            ST_BODY,
            ST_SUM_HI,
            ST_SUM_LO
        } link_phase_t;

        res_t        pending_replies[$];

        link_phase_t phase;
        logic [7:0]  running_sum;
        logic [8:0]  body_count;
        logic [3:0]  sum_hi;
        logic [7:0]  payload[BUF_DEPTH];
        logic [8:0]  kept_len;
        logic        kept_seq;

        int errors;
        int checked;
        int good_pkts;
        int bad_pkts;
        int aborts;
        int reads;

        function new();
            phase       = ST_HUNT;
            running_sum = 8'd0;
            body_count  = 9'd0;
            sum_hi      = 4'd0;
            kept_len    = 9'd0;
            kept_seq    = 1'b0;
        endfunction

        static function logic [3:0] nibble_of(input logic [7:0] c);
            if (c >= "A" && c <= "F")
                return 4'(c - "A" + 10);
            if (c >= "a" && c <= "f")
                return 4'(c - "a" + 10);
            if (c >= "0" && c <= "9")
                return 4'(c - "0");
            return 4'd0;
        endfunction

        function void push_reply(input logic [1:0] kind, input logic [7:0] data,
                                 input logic good, input logic [8:0] len,
                                 input logic seq, input logic ab);
            res_t r;
            r.kind    = kind;
            r.data    = data;
            r.good    = good;
            r.len     = len;
            r.seq     = seq;
            r.aborted = ab;
            r.last    = 1'b0;
            pending_replies.push_back(r);
        endfunction

        // Advance the receiver state by one accepted transfer and queue the replies.
        // Return 0 when the block simply ignores the item.
        function bit predict_replies(input logic [1:0] kind, input logic [7:0] b,
                                     input logic [8:0] idx);
            int         base;
            int         addr;
            logic [7:0] sent;
            logic [7:0] v;
            base = pending_replies.size();
            case (kind)
                IN_KIND_BYTE:
                begin
                    case (phase)
                        ST_HUNT:
                        begin
                            if (b != CH_DOLLAR)
                                return 1'b0;
                            phase       = ST_BODY;
                            running_sum = 8'd0;
                            body_count  = 9'd0;
                        end
                        ST_BODY:
                        begin
                            if (b == CH_HASH)
                                phase = ST_SUM_HI;
                            else if (body_count < BUF_DEPTH - 1)
                            begin
                                payload[body_count] = b;
                                running_sum         = running_sum + b;
                                body_count          = body_count + 9'd1;
                                // drop the packet once the store holds BUF_DEPTH - 1 bytes
                                if (body_count >= BUF_DEPTH - 1)
                                    phase = ST_HUNT;
                            end
                            else
                                phase = ST_HUNT;
                        end
                        ST_SUM_HI:
                        begin
                            sum_hi = nibble_of(b);
                            phase  = ST_SUM_LO;
                        end
                        default:
                        begin
                            sent  = {sum_hi, nibble_of(b)};
                            phase = ST_HUNT;
                            if (sent != running_sum)
                            begin
                                kept_len = body_count;
                                kept_seq = 1'b0;
                                push_reply(OUT_KIND_BYTE, CH_MINUS, 1'b0, 9'd0, 1'b0, 1'b0);
                                push_reply(OUT_KIND_VERDICT, 8'd0, 1'b0, body_count,
                                           1'b0, 1'b0);
                                bad_pkts++;
                            end
                            else
                            begin
                                push_reply(OUT_KIND_BYTE, CH_PLUS, 1'b0, 9'd0, 1'b0, 1'b0);
                                if (body_count >= 3 && payload[2] == CH_COLON)
                                begin
                                    push_reply(OUT_KIND_BYTE, payload[0], 1'b0, 9'd0,
                                               1'b0, 1'b0);
                                    push_reply(OUT_KIND_BYTE, payload[1], 1'b0, 9'd0,
                                               1'b0, 1'b0);
                                    kept_len = body_count - 9'd3;
                                    kept_seq = 1'b1;
                                end
                                else
                                begin
                                    kept_len = body_count;
                                    kept_seq = 1'b0;
                                end
                                push_reply(OUT_KIND_VERDICT, 8'd0, 1'b1, kept_len,
                                           kept_seq, 1'b0);
                                good_pkts++;
                            end
                        end
                    endcase
                end
                IN_KIND_END:
                begin
                    phase = ST_HUNT;
                    push_reply(OUT_KIND_VERDICT, 8'd0, 1'b0, 9'd0, 1'b0, 1'b1);
                    aborts++;
                end
                IN_KIND_READ:
                begin
                    v = 8'd0;
                    if (idx < kept_len)
                    begin
                        addr = int'(idx) + (kept_seq ? 3 : 0);
                        if (addr < BUF_DEPTH)
                            v = payload[addr];
                    end
                    push_reply(OUT_KIND_DATA, v, 1'b0, 9'd0, 1'b0, 1'b0);
                    reads++;
                end
                default:
                    return 1'b0;
            endcase
            if (pending_replies.size() > base)
                pending_replies[pending_replies.size() - 1].last = 1'b1;
            return 1'b1;
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_reply(input res_t got);
            res_t want;
            checked++;
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual kind %0d byte %h",
                         $time, got.kind, got.data);
                return;
            end
            want = pending_replies.pop_front();
            compare_field("out_kind", want.kind, got.kind);
            compare_field("out_byte", want.data, got.data);
            compare_field("packet_good", want.good, got.good);
            compare_field("packet_length", want.len, got.len);
            compare_field("seq_present", want.seq, got.seq);
            compare_field("aborted", want.aborted, got.aborted);
            compare_field("last", want.last, got.last);
        endfunction

    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 24'd0;  // rx_byte[7:0], read_index[16:8], zero[23:17]
    logic [1:0]  s_axis_tuser = 2'd0;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [23:0] m_axis_tdata;          // out_byte[7:0], packet_good[8],
                                        // packet_length[17:9], seq_present[18],
                                        // aborted[19], zero[23:20]
    logic [1:0]  m_axis_tuser;          // out_kind[1:0]
    logic        m_axis_tlast;

    reply_scoreboard sb = new();

    bit src_gaps    = 1'b1;
    bit sink_stalls = 1'b1;
    int used_items  = 0;
    int quiet_cycles = 0;

    debug_packet_receiver_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin : result_monitor
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind    = m_axis_tuser;
            got.data    = m_axis_tdata[7:0];
            got.good    = m_axis_tdata[8];
            got.len     = m_axis_tdata[17:9];
            got.seq     = m_axis_tdata[18];
            got.aborted = m_axis_tdata[19];
            got.last    = m_axis_tlast;
            sb.check_reply(got);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side back-pressure in random bursts.
    initial
    begin : sink_stall_gen
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 6) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [7:0] b,
                             input logic [8:0] idx);
        if (src_gaps && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, idx, b};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (sb.predict_replies(kind, b, idx))
            used_items++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(IN_KIND_BYTE, b, 9'($urandom));
    endtask

    task automatic read_payload(input logic [8:0] idx);
        send_item(IN_KIND_READ, 8'($urandom), idx);
    endtask

    // Hold the input idle until every queued reply has left the block.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_replies.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == CH_HASH);
        return b;
    endfunction

    // Zero digits sometimes travel as a non-hex character, which also counts as zero.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n == 4'd0 && $urandom_range(0, 3) == 0)
        begin
            do
                c = 8'($urandom);
            while (reply_scoreboard::nibble_of(c) != 4'd0);
        end
        else if (n < 4'd10)
            c = 8'h30 + 8'(n);
        else
            c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
        return c;
    endfunction

    // Send a framed packet; abort_at names the frame position replaced by a
    // connection end, or -1 for a complete frame.
    task automatic send_packet(input logic [7:0] body[$], input bit corrupt,
                               input int abort_at);
        logic [7:0] frame[$];
        logic [7:0] sum;
        sum = 8'd0;
        foreach (body[k])
            sum = sum + body[k];
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        frame = body;
        frame.push_front(CH_DOLLAR);
        frame.push_back(CH_HASH);
        frame.push_back(hex_char(sum[7:4]));
        frame.push_back(hex_char(sum[3:0]));
        foreach (frame[k])
        begin
            if (k == abort_at)
            begin
                send_item(IN_KIND_END, 8'($urandom), 9'($urandom));
                return;
            end
            send_byte(frame[k]);
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] body[$];
        int         len;
        int         r;
        int         abort_at;
        bit         corrupt;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, ignored bytes and unknown kind
        read_payload(9'd0);
        read_payload(9'd511);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_item(2'd3, 8'hFF, 9'd511);

        // upper and lower case checksum digits
        send_byte(CH_DOLLAR);
        send_byte(8'hFF);
        send_byte(CH_HASH);
        send_byte("F");
        send_byte("f");
        read_payload(9'd0);

        // bad checksum
        send_packet('{8'h00}, 1'b1, -1);

        // non-hex digits count as zero
        send_byte(CH_DOLLAR);
        send_byte(CH_HASH);
        send_byte("z");
        send_byte(8'hFF);

        // sequence id echoed and stripped
        send_packet('{"1", "2", CH_COLON, "a", "b"}, 1'b0, -1);
        read_payload(9'd0);
        read_payload(9'd1);
        read_payload(9'd2);

        // connection end mid-packet and while hunting
        send_packet('{"x", "y"}, 1'b0, 2);
        send_item(IN_KIND_END, 8'h00, 9'd0);
        read_payload(9'd0);

        // id with nothing behind it
        send_packet('{"9", "8", CH_COLON}, 1'b0, -1);

        wait_drained();

        while (used_items < ITEM_TARGET)
        begin
            if (used_items >= ITEM_TARGET - 60)
            begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                src_gaps    = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            if (used_items < ITEM_TARGET - 60 && $urandom_range(0, 59) == 0)
                wait_drained();

            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                repeat ($urandom_range(0, 2))
                begin
                    do
                        len = $urandom_range(0, 255);
                    while (len == CH_DOLLAR);
                    send_byte(8'(len));
                end
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(0, 12);
                body.delete();
                repeat (len) body.push_back(payload_byte());
                if (len >= 3 && $urandom_range(0, 1) == 1)
                    body[2] = CH_COLON;
                corrupt  = ($urandom_range(0, 4) == 0);
                abort_at = ($urandom_range(0, 11) == 0) ? $urandom_range(1, len + 3) : -1;
                send_packet(body, corrupt, abort_at);
            end
            else if (r < 85)
            begin
                if ($urandom_range(0, 9) < 7)
                    read_payload(9'($urandom_range(0, int'(sb.kept_len) + 1)));
                else
                    read_payload(9'($urandom_range(0, 511)));
            end
            else if (r < 91)
                send_item(IN_KIND_END, 8'($urandom), 9'($urandom));
            else if (r < 97)
                send_byte(8'($urandom));
            else
                send_item(2'd3, 8'($urandom), 9'($urandom));
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_replies.size() != 0) @(posedge clk);
        repeat (QUIET_TAIL) @(posedge clk);

        $display("Covered framed packets with and without sequence ids, %0d good, %0d bad sums,",
                 sb.good_pkts, sb.bad_pkts);
        $display("%0d connection ends and %0d payload reads; %0d results compared, %0d errors",
                 sb.aborts, sb.reads, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
